// ===== hw/rtl/rlesd_pkg.sv =====
// shared types, constants and color helpers for the run-length sprite decoder
package rlesd_pkg;

    localparam int PAL_DEPTH_DEF = 256;
    localparam int MAX_DIM_DEF   = 2048;

    localparam int DIM_W   = 12;   // width, height, row and column registers
    localparam int CMP_W   = 13;   // room for a dimension limit of 4096
    localparam int CNT_W   = 9;    // palette count register
    localparam int COORD_W = 11;   // pixel_x / pixel_y
    localparam int CHAN_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int LUM_W   = 10;

    localparam logic [DIM_W-1:0] COL_MAX = 12'hFFF;
    localparam logic [LUM_W-1:0] LUM_MIN = 10'd24;
    localparam logic [LUM_W-1:0] LUM_MAX = 10'd255;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PALETTE = 2'd1,
        OP_BODY    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_PAL_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_SKIP  = 2'd1,
        PH_NCOL  = 2'd2,
        PH_INDEX = 2'd3
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CNT_W-1:0] pal_count;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               use_pal;
        logic [BYTE_W-1:0]  index;
    } pix_req_t;

    // floor(v * 255 / 31) = 8v + floor(7v / 31)
    function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
        logic [7:0] t;
        logic [2:0] f;
        t = {v, 3'b000} - {3'b000, v};
        f = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (t >= 8'(31 * k)) begin
                f = f + 3'd1;
            end
        end
        return {v, 3'b000} + {5'b00000, f};
    endfunction

    // floor(v * 255 / 63) = 4v + floor(v / 21)
    function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'd0;
        for (int k = 1; k < 4; k++) begin
            if (v >= 6'(21 * k)) begin
                f = f + 2'd1;
            end
        end
        return {v, 2'b00} + {6'b000000, f};
    endfunction

endpackage

// ===== hw/rtl/rlesd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module rlesd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rlesd_parser.sv =====
// body parser: row, column, packet and color counters and pixel request generation
module rlesd_parser import rlesd_pkg::*; #(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
    parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              beat,
    input  logic [1:0]        opcode,
    input  logic [BYTE_W-1:0] body_byte,
    output logic              emit,
    output pix_req_t          req
);

    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIMENSION);
    localparam logic [CNT_W-1:0] PAL_LIMIT = CNT_W'(PALETTE_DEPTH);

    phase_t            phase_reg, phase_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [BYTE_W-1:0] pk_reg, pk_next;
    logic [BYTE_W-1:0] cl_reg, cl_next;
    logic              fin_reg, fin_next;

    logic [CMP_W-1:0]  w_eff, h_eff, col_sum;
    logic [CNT_W-1:0]  cnt_eff;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic [BYTE_W-1:0] pk_dec, cl_dec;
    logic              row_hi, in_width, pal_ok;
    logic              pkt_done, row_done;

    assign w_eff   = ({1'b0, cfg.width} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, cfg.width};
    assign h_eff   = ({1'b0, cfg.height} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, cfg.height};
    assign cnt_eff = (cfg.pal_count > PAL_LIMIT) ? PAL_LIMIT : cfg.pal_count;

    assign col_sum = {1'b0, col_reg} + {{(CMP_W-BYTE_W){1'b0}}, body_byte};
    assign col_inc = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
    assign row_inc = (row_reg == COL_MAX) ? row_reg : row_reg + 1'b1;
    assign pk_dec  = pk_reg - 1'b1;
    assign cl_dec  = cl_reg - 1'b1;

    assign row_hi   = {1'b0, row_reg} >= h_eff;
    assign in_width = {1'b0, col_reg} < w_eff;
    // direct color mode takes every index, palette mode drops 0 and out-of-range
    assign pal_ok   = (cfg.pal_count == '0) ||
                      ((body_byte != '0) && ({1'b0, body_byte} < cnt_eff));

    assign req.x       = col_reg[COORD_W-1:0];
    assign req.y       = row_reg[COORD_W-1:0];
    assign req.use_pal = cfg.pal_count != '0;
    assign req.index   = body_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COUNT;
            row_reg   <= '0;
            col_reg   <= '0;
            pk_reg    <= '0;
            cl_reg    <= '0;
            fin_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pk_reg    <= pk_next;
            cl_reg    <= cl_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pk_next    = pk_reg;
        cl_next    = cl_reg;
        fin_next   = fin_reg;
        emit       = 1'b0;
        pkt_done   = 1'b0;
        row_done   = 1'b0;

        if (beat) begin
            case (opcode)
                OP_START: begin
                    phase_next = PH_COUNT;
                    row_next   = '0;
                    col_next   = '0;
                    pk_next    = '0;
                    cl_next    = '0;
                    fin_next   = 1'b0;
                end
                OP_BODY: begin
                    if (fin_reg || row_hi) begin
                        fin_next = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            PH_COUNT: begin
                                col_next = '0;
                                pk_next  = body_byte;
                                if (body_byte == '0) begin
                                    row_done = 1'b1;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            PH_SKIP: begin
                                col_next   = col_sum[CMP_W-1] ? COL_MAX : col_sum[DIM_W-1:0];
                                phase_next = PH_NCOL;
                            end
                            PH_NCOL: begin
                                cl_next = body_byte;
                                if (body_byte == '0) begin
                                    pkt_done = 1'b1;
                                end else begin
                                    phase_next = PH_INDEX;
                                end
                            end
                            PH_INDEX: begin
                                emit     = in_width && pal_ok;
                                col_next = col_inc;
                                cl_next  = cl_dec;
                                if (cl_dec == '0) begin
                                    pkt_done = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (pkt_done) begin
            pk_next = pk_dec;
            if (pk_dec == '0) begin
                row_done = 1'b1;
            end else begin
                phase_next = PH_SKIP;
            end
        end

        if (row_done) begin
            row_next   = row_inc;
            col_next   = '0;
            pk_next    = '0;
            cl_next    = '0;
            phase_next = PH_COUNT;
            if ({1'b0, row_inc} >= h_eff) begin
                fin_next = 1'b1;
            end
        end
    end

    // inside a row at least one packet is still open
    a_packets_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_COUNT) |-> (pk_reg != '0))
        else $error("packet counter empty outside the count phase");

    // index phase always has a color left to take
    a_colors_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_INDEX) |-> (cl_reg != '0))
        else $error("color counter empty in the index phase");

    // a pixel only comes out of an accepted body beat
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (beat && (opcode == OP_BODY) && (phase_reg == PH_INDEX)))
        else $error("pixel request outside an index beat");

endmodule

// ===== hw/rtl/rlesd_color.sv =====
// palette lookup stage, ARGB expansion and output register
module rlesd_color import rlesd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  pix_req_t           req,
    input  logic [COLOR_W-1:0] pal_data,
    output logic               stage_ready,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [COORD_W-1:0] m_pixel_x,
    output logic [COORD_W-1:0] m_pixel_y,
    output logic [CHAN_W-1:0]  m_alpha,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue
);

    logic     s1_valid_reg, s1_valid_next;
    pix_req_t s1_req_reg;
    logic     m_valid_reg, m_valid_next;
    logic     s1_adv;

    logic [COLOR_W-1:0] c16;
    logic [4:0]         r5, b5;
    logic [5:0]         g6;
    logic [LUM_W-1:0]   lum;
    logic [CHAN_W-1:0]  a_calc, r_calc, g_calc, b_calc;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic [CHAN_W-1:0]  a_reg, r_reg, g_reg, b_reg;

    assign s1_adv      = s1_valid_reg && (!m_valid_reg || m_ready);
    assign stage_ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next = load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = s1_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // direct mode reads the index byte itself as rgb565
    assign c16 = s1_req_reg.use_pal ? pal_data : {8'h00, s1_req_reg.index};
    assign r5  = c16[15:11];
    assign g6  = c16[10:5];
    assign b5  = c16[4:0];
    assign lum = {2'b00, r5, 3'b000} + {2'b00, g6, 2'b00} + {2'b00, b5, 3'b000};

    always_comb begin
        r_calc = expand5(r5);
        g_calc = expand6(g6);
        b_calc = expand5(b5);
        a_calc = 8'hFF;
        if (s1_req_reg.use_pal) begin
            if (lum < LUM_MIN) begin
                // too dark: fully transparent black
                r_calc = '0;
                g_calc = '0;
                b_calc = '0;
                a_calc = '0;
            end else begin
                a_calc = (lum > LUM_MAX) ? 8'hFF : lum[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_req_reg <= req;
        end
        if (s1_adv) begin
            x_reg <= s1_req_reg.x;
            y_reg <= s1_req_reg.y;
            a_reg <= a_calc;
            r_reg <= r_calc;
            g_reg <= g_calc;
            b_reg <= b_calc;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pixel_x = x_reg;
    assign m_pixel_y = y_reg;
    assign m_alpha   = a_reg;
    assign m_red     = r_reg;
    assign m_green   = g_reg;
    assign m_blue    = b_reg;

    // a loaded request sits in the lookup stage on the next cycle
    a_load_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> s1_valid_reg)
        else $error("lookup stage empty after a load");

    // a full lookup stage behind a stalled output blocks new beats
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> (!stage_ready && !load))
        else $error("new beat taken while the pipeline is stalled");

    // output drains when taken with nothing behind it
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !s1_valid_reg) |=> !m_valid_reg)
        else $error("output beat repeated");

endmodule

// ===== hw/rtl/rle_palette_sprite_decoder.sv =====
// top level of the run-length palette sprite decoder
//
//  channel   ports                 width/fields                         handshake
//  input     s_valid/s_ready       opcode 2, entry_index 8,             valid/ready
//                                  entry_color 16, body_byte 8
//  result    m_valid/m_ready       pixel_x 11, pixel_y 11, alpha 8,     valid/ready
//                                  red 8, green 8, blue 8
//  config    cfg_wr_en             cfg_addr 2, cfg_wdata 12             write only
//
// one beat per cycle while s_ready is high; a pixel goes from its index beat through
// the palette ram read into the lookup stage, then color expansion into the output register.
// the parser state lives in flops, the palette in a registered-read ram.
// a stalled result holds one pixel in the lookup stage and one at the output,
// and the input stops only when both are full.
// reset clears the parser, sets width and height to 1 and palette count to 0; palette contents stay undefined.
module rle_palette_sprite_decoder import rlesd_pkg::*; #(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
    parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [DIM_W-1:0]   cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [7:0]         s_entry_index,
    input  logic [15:0]        s_entry_color,
    input  logic [7:0]         s_body_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_pixel_x,
    output logic [COORD_W-1:0] m_pixel_y,
    output logic [CHAN_W-1:0]  m_alpha,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [CNT_W-1:0] PAL_LIMIT = CNT_W'(PALETTE_DEPTH);

    cfg_t     cfg_reg, cfg_next;
    logic     beat;
    logic     emit;
    pix_req_t req;
    logic     stage_ready;
    logic     pal_wr_en;
    logic [COLOR_W-1:0] pal_data;

    assign s_ready = stage_ready;
    assign beat    = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WIDTH:     cfg_next.width     = cfg_wdata;
                REG_HEIGHT:    cfg_next.height    = cfg_wdata;
                REG_PAL_COUNT: cfg_next.pal_count = cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width     <= DIM_W'(1);
            cfg_reg.height    <= DIM_W'(1);
            cfg_reg.pal_count <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // entries beyond the palette depth are dropped
    assign pal_wr_en = beat && (s_opcode == OP_PALETTE) &&
                       ({1'b0, s_entry_index} < PAL_LIMIT);

    rlesd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (s_entry_index[AW-1:0]),
        .wr_data (s_entry_color),
        .rd_en   (emit),
        .rd_addr (s_body_byte[AW-1:0]),
        .rd_data (pal_data)
    );

    rlesd_parser #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .beat      (beat),
        .opcode    (s_opcode),
        .body_byte (s_body_byte),
        .emit      (emit),
        .req       (req)
    );

    rlesd_color u_color (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (emit),
        .req         (req),
        .pal_data    (pal_data),
        .stage_ready (stage_ready),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_pixel_x   (m_pixel_x),
        .m_pixel_y   (m_pixel_y),
        .m_alpha     (m_alpha),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

endmodule
